/* rtl/battery_level_gauge_core_macros.svh */
// Assertion helpers shared by the gauge modules.
// Each use expects clk_i and rst_ni in scope.
`ifndef BATTERY_LEVEL_GAUGE_CORE_MACROS_SVH
`define BATTERY_LEVEL_GAUGE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/blg_pkg.sv */
`timescale 1ns / 1ps

package blg_pkg;

  // Field widths fixed by the register map and the result format.
  localparam int LIMIT_W    = 12;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Fixed point format of the running average.
  localparam int FRAC_BITS = 8;

  // Restoring divider: one quotient bit per step, the top bit flags saturation.
  localparam int DIV_STEPS = 9;
  localparam int Q_W       = 9;
  localparam int STEP_W    = 4;

  localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;
  localparam logic [PCT_W-1:0] ZERO_PERCENT = 7'd0;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_PERCENT = 2'd2;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST     = 12'd330;
  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST    = 12'd420;
  localparam logic [PCT_W-1:0]   ALARM_PERCENT_RST = 7'd15;

  // Which way a sample was classified against the limits.
  typedef enum logic [1:0] {
    PATH_BELOW = 2'd0,
    PATH_ABOVE = 2'd1,
    PATH_IN    = 2'd2
  } path_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic classify;
    logic read;
    logic accum;
    logic scale;
    logic div_step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;
    logic last_entry;
    logic div_skip;
    logic div_done;
  } status_t;

endpackage

/* rtl/blg_ctrl.sv */
`timescale 1ns / 1ps
`include "battery_level_gauge_core_macros.svh"

module blg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  blg_pkg::status_t status_i,
  output blg_pkg::cmd_t    cmd_o
);
  import blg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLASS = 7'b0000010,
    S_READ  = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_SCALE = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_take;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;

  // Sequencer: one item at a time from capture to result.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd_o.classify = 1'b1;
        state_d        = status_i.in_range ? S_READ : S_FIN;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_ACC;
      end
      S_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = status_i.last_entry ? S_SCALE : S_READ;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_skip) begin
          state_d = S_FIN;
        end else begin
          cmd_o.div_step = 1'b1;
          if (status_i.div_done) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set when a result is loaded, cleared when its beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `BLG_ASSERT_SAME(a_finish_needs_room, cmd_o.finish, out_free, "result loaded over a held beat")
  `BLG_ASSERT_NEXT(a_take_goes_class, in_take, state_q == S_CLASS, "accepted beat not classified")

endmodule

/* rtl/blg_dpath.sv */
`timescale 1ns / 1ps
`include "battery_level_gauge_core_macros.svh"

module blg_dpath #(
  parameter int DEPTH       = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [blg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [blg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]          voltage_sample_i,
  input  blg_pkg::cmd_t                   cmd_i,
  output blg_pkg::status_t                status_o,
  output logic [blg_pkg::PCT_W-1:0]       level_percent_o,
  output logic                            low_alarm_o,
  output logic                            report_level_o,
  output logic                            report_alarm_o
);
  import blg_pkg::*;

  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int SW     = SAMPLE_BITS;
  localparam int CMPS_W = (SW > LIMIT_W) ? SW : LIMIT_W;
  localparam int ACC_W  = SW + FRAC_BITS;
  localparam int LO8_W  = LIMIT_W + FRAC_BITS;
  localparam int CMP_W  = (ACC_W > LO8_W) ? ACC_W : LO8_W;
  localparam int NUM_W  = ACC_W + PCT_W;
  localparam int DEN_W  = LIMIT_W + 2 * FRAC_BITS;
  localparam int DIV_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;

  // Configuration registers.
  logic [LIMIT_W-1:0] low_lim_q;
  logic [LIMIT_W-1:0] high_lim_q;
  logic [PCT_W-1:0]   alarm_pct_q;

  // Item state.
  logic [SW-1:0]      samp_q;
  path_e              path_q;
  logic [AW-1:0]      slot_q;
  logic [CW-1:0]      fill_q;
  logic [AW-1:0]      rd_idx_q;
  logic [SW-1:0]      rd_data_q;
  logic [ACC_W-1:0]   acc_q;
  logic               degen_q;
  logic               zero_q;
  logic [DIV_W-1:0]   rem_q;
  logic [DIV_W-1:0]   den_q;
  logic [Q_W-1:0]     quot_q;
  logic [STEP_W-1:0]  step_q;

  // Gauge state and the result register.
  logic [PCT_W-1:0]   level_q;
  logic               level_pend_q;
  logic               alarm_q;
  logic               alarm_pend_q;
  logic [PCT_W-1:0]   out_level_q;
  logic               out_alarm_q;
  logic               out_rep_level_q;
  logic               out_rep_alarm_q;

  logic [SW-1:0]      store_mem [DEPTH];

  logic               below;
  logic               above;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   entry_q8;
  logic [CMP_W-1:0]   lo8_ext;
  logic [CMP_W-1:0]   avg_ext;
  logic [CMP_W-1:0]   diff_full;
  logic [ACC_W-1:0]   diff;
  logic [LIMIT_W-1:0] span;
  logic               div_ge;
  logic [PCT_W-1:0]   pct;
  logic [PCT_W-1:0]   new_level;
  logic               alarm_new;
  logic               level_chg;
  logic               alarm_chg;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_lim_q   <= LOW_LIMIT_RST;
      high_lim_q  <= HIGH_LIMIT_RST;
      alarm_pct_q <= ALARM_PERCENT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOW_LIMIT:     low_lim_q   <= cfg_data_i[LIMIT_W-1:0];
        CFG_HIGH_LIMIT:    high_lim_q  <= cfg_data_i[LIMIT_W-1:0];
        CFG_ALARM_PERCENT: alarm_pct_q <= cfg_data_i[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Limit check on the captured sample.
  assign below = CMPS_W'(samp_q) < CMPS_W'(low_lim_q);
  assign above = CMPS_W'(samp_q) > CMPS_W'(high_lim_q);

  assign status_o.in_range   = !below && !above;
  assign status_o.last_entry = (CW'(rd_idx_q) + CW'(1)) == fill_q;
  assign status_o.div_skip   = degen_q || zero_q;
  assign status_o.div_done   = step_q == STEP_W'(DIV_STEPS - 1);

  // Sample store: one write per in-limit item, one registered read per entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.classify && status_o.in_range) begin
      store_mem[slot_q] <= samp_q;
    end
    if (cmd_i.read) begin
      rd_data_q <= store_mem[rd_idx_q];
    end
  end

  // Ring pointer and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.classify && status_o.in_range) begin
      slot_q <= (slot_q == AW'(DEPTH - 1)) ? '0 : slot_q + AW'(1);
      if (fill_q != CW'(DEPTH)) begin
        fill_q <= fill_q + CW'(1);
      end
    end
  end

  // Capture, classification and the read index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      samp_q <= voltage_sample_i;
    end
    if (cmd_i.classify) begin
      rd_idx_q <= '0;
      if (below) begin
        path_q <= PATH_BELOW;
      end else if (above) begin
        path_q <= PATH_ABOVE;
      end else begin
        path_q <= PATH_IN;
      end
    end else if (cmd_i.accum) begin
      rd_idx_q <= rd_idx_q + AW'(1);
    end
  end

  // Cascaded pairwise average with truncation at every step.
  assign entry_q8 = {rd_data_q, FRAC_BITS'(0)};
  assign acc_sum  = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(entry_q8);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accum) begin
      acc_q <= (rd_idx_q == '0) ? entry_q8 : acc_sum[ACC_W:1];
    end
  end

  // Scaling: offset from the low limit times 100, divided by the span.
  assign lo8_ext   = CMP_W'({low_lim_q, FRAC_BITS'(0)});
  assign avg_ext   = CMP_W'(acc_q);
  assign diff_full = avg_ext - lo8_ext;
  assign diff      = diff_full[ACC_W-1:0];
  assign span      = high_lim_q - low_lim_q;
  assign div_ge    = rem_q >= den_q;

  // Restoring divider, one quotient bit per cycle from the saturation bit down.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      degen_q <= high_lim_q <= low_lim_q;
      zero_q  <= avg_ext <= lo8_ext;
      rem_q   <= DIV_W'(NUM_W'(diff) * NUM_W'(FULL_PERCENT));
      den_q   <= DIV_W'(span) << (2 * FRAC_BITS);
      quot_q  <= '0;
      step_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - den_q;
      end
      den_q  <= den_q >> 1;
      quot_q <= {quot_q[Q_W-2:0], div_ge};
      step_q <= step_q + STEP_W'(1);
    end
  end

  // Final percent with saturation and the degenerate span.
  always_comb begin
    if (degen_q) begin
      pct = FULL_PERCENT;
    end else if (zero_q) begin
      pct = ZERO_PERCENT;
    end else if (quot_q[Q_W-1] || (quot_q[Q_W-2:0] > (Q_W - 1)'(FULL_PERCENT))) begin
      pct = FULL_PERCENT;
    end else begin
      pct = quot_q[PCT_W-1:0];
    end
  end

  always_comb begin
    unique case (path_q)
      PATH_BELOW: new_level = ZERO_PERCENT;
      PATH_ABOVE: new_level = FULL_PERCENT;
      PATH_IN:    new_level = pct;
      default:    new_level = pct;
    endcase
  end

  assign alarm_new = new_level <= alarm_pct_q;
  assign level_chg = new_level != level_q;
  assign alarm_chg = alarm_new != alarm_q;

  // Gauge state: level, alarm and the pending change flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q      <= '0;
      level_pend_q <= 1'b0;
      alarm_q      <= 1'b0;
      alarm_pend_q <= 1'b0;
    end else if (cmd_i.finish) begin
      level_q <= new_level;
      if (path_q == PATH_IN) begin
        alarm_q      <= alarm_new;
        level_pend_q <= 1'b0;
        alarm_pend_q <= 1'b0;
      end else if (level_chg) begin
        level_pend_q <= 1'b1;
      end
    end
  end

  // Result register, loaded once per item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_level_q <= new_level;
      if (path_q == PATH_IN) begin
        out_alarm_q     <= alarm_new;
        out_rep_level_q <= level_pend_q || level_chg;
        out_rep_alarm_q <= alarm_pend_q || alarm_chg;
      end else begin
        out_alarm_q     <= alarm_q;
        out_rep_level_q <= 1'b0;
        out_rep_alarm_q <= 1'b0;
      end
    end
  end

  assign level_percent_o = out_level_q;
  assign low_alarm_o     = out_alarm_q;
  assign report_level_o  = out_rep_level_q;
  assign report_alarm_o  = out_rep_alarm_q;

  `BLG_ASSERT_SAME(a_read_filled, cmd_i.read, CW'(rd_idx_q) < fill_q, "read of an unfilled entry")
  `BLG_ASSERT_NEXT(a_pend_cleared, cmd_i.finish && (path_q == PATH_IN), !level_pend_q && !alarm_pend_q, "pending flags survived a report")

endmodule

/* rtl/battery_level_gauge_core.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake                Beat contents
// in       input      in_valid_i / in_stall_o  voltage_sample_i
// out      output     out_valid_o / out_stall_i level_percent_o, low_alarm_o,
//                                               report_level_o, report_alarm_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An out-of-limit sample goes from capture and classification straight to result.
// An in-limit sample is stored; then each of the N filled store entries (at most
// DEPTH) is read through the registered store read and accumulated, the average
// is scaled, and the divider runs; it skips its steps when the span is degenerate
// or the average sits at or below the low limit.
// Reset clears the control state and loads the limits 330 and 420 and alarm 15.
// A finished result waits in the output register while out_stall_i is high; the
// next item is accepted meanwhile and holds before its own result until room frees.

module battery_level_gauge_core #(
  parameter int DEPTH       = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [SAMPLE_BITS-1:0]         voltage_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [blg_pkg::PCT_W-1:0]      level_percent_o,
  output logic                           low_alarm_o,
  output logic                           report_level_o,
  output logic                           report_alarm_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [blg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [blg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import blg_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  // Registers accept a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  blg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  blg_dpath #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .voltage_sample_i (voltage_sample_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .level_percent_o  (level_percent_o),
    .low_alarm_o      (low_alarm_o),
    .report_level_o   (report_level_o),
    .report_alarm_o   (report_alarm_o)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import blg_pkg::*;

  localparam int DEPTH          = 10;
  localparam int SAMPLE_BITS    = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 2 * DEPTH + 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_SAMPLES  = 58;

  // The register port decodes two index bits; index 3 addresses no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // One result beat as the output ports carry it.
  typedef struct packed {
    logic [PCT_W-1:0] level;
    logic             alarm;
    logic             rep_level;
    logic             rep_alarm;
  } gauge_beat_t;

  // Rows of the directed script: a register write, a sample checked against
  // the predictor, or a sample whose result is typed into the row.
  typedef enum logic [1:0] {
    ROW_CFG     = 2'd0,
    ROW_PREDICT = 2'd1,
    ROW_TYPED   = 2'd2
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [LIMIT_W-1:0]    value;
    gauge_beat_t           want;
  } script_row_t;

  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   in_valid_i       = 1'b0;
  logic                   in_stall_o;
  logic [SAMPLE_BITS-1:0] voltage_sample_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i      = 1'b0;
  logic [PCT_W-1:0]       level_percent_o;
  logic                   low_alarm_o;
  logic                   report_level_o;
  logic                   report_alarm_o;
  logic                   cfg_valid_i      = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i      = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i       = '0;

  // Predicted gauge state and register copies.
  int unsigned      kept_samples [DEPTH];
  int unsigned      next_slot;
  int unsigned      kept_count;
  logic [PCT_W-1:0] cur_level;
  logic             level_dirty;
  logic             cur_alarm;
  logic             alarm_dirty;
  int unsigned      empty_v;
  int unsigned      full_v;
  int unsigned      alarm_at;

  gauge_beat_t expected_beats[$];
  gauge_beat_t head_beat;

  int  mismatches    = 0;
  int  samples_sent  = 0;
  int  beats_checked = 0;
  int  reg_writes    = 0;
  int  settings_used = 0;
  int  quiet_cycles  = 0;
  int  stall_run     = 0;
  bit  idle_off      = 1'b0;

  battery_level_gauge_core #(
    .DEPTH      (DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .voltage_sample_i(voltage_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .level_percent_o (level_percent_o),
    .low_alarm_o     (low_alarm_o),
    .report_level_o  (report_level_o),
    .report_alarm_o  (report_alarm_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Advance the predicted gauge by one sample and return the beat it causes.
  function automatic gauge_beat_t advance_gauge(input logic [LIMIT_W-1:0] s);
    int unsigned acc;
    int unsigned lo_q;
    int unsigned span_q;
    int unsigned pct;
    int unsigned i;
    gauge_beat_t beat;
    beat = '0;
    if (s < empty_v) begin
      if (cur_level != ZERO_PERCENT) begin
        cur_level   = ZERO_PERCENT;
        level_dirty = 1'b1;
      end
    end else if (s > full_v) begin
      if (cur_level != FULL_PERCENT) begin
        cur_level   = FULL_PERCENT;
        level_dirty = 1'b1;
      end
    end else begin
      kept_samples[next_slot] = s;
      next_slot = (next_slot == DEPTH - 1) ? 0 : next_slot + 1;
      if (kept_count < DEPTH) kept_count++;

      // Cascaded pairwise average over the filled entries, in index order.
      acc = kept_samples[0] << FRAC_BITS;
      for (i = 1; i < kept_count; i++) begin
        acc = (acc + (kept_samples[i] << FRAC_BITS)) >> 1;
      end

      // Scale between the limits, truncating and saturating.
      lo_q = empty_v << FRAC_BITS;
      if (full_v <= empty_v) begin
        pct = 100;
      end else if (acc <= lo_q) begin
        pct = 0;
      end else begin
        span_q = (full_v - empty_v) << FRAC_BITS;
        pct = ((acc - lo_q) * 100) / span_q;
        if (pct > 100) pct = 100;
      end
      if (cur_level != PCT_W'(pct)) begin
        cur_level   = PCT_W'(pct);
        level_dirty = 1'b1;
      end
      if (cur_alarm != (cur_level <= alarm_at)) begin
        cur_alarm   = (cur_level <= alarm_at);
        alarm_dirty = 1'b1;
      end
      beat.rep_level = level_dirty;
      beat.rep_alarm = alarm_dirty;
      level_dirty = 1'b0;
      alarm_dirty = 1'b0;
    end
    beat.level = cur_level;
    beat.alarm = cur_alarm;
    return beat;
  endfunction

  function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    script_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.value = data;
    return r;
  endfunction

  function automatic script_row_t sample_row(input logic [LIMIT_W-1:0] s);
    script_row_t r;
    r       = '0;
    r.kind  = ROW_PREDICT;
    r.value = s;
    return r;
  endfunction

  function automatic script_row_t typed_row(input logic [LIMIT_W-1:0] s,
                                            input logic [PCT_W-1:0] level,
                                            input logic alarm, input logic rep_level,
                                            input logic rep_alarm);
    script_row_t r;
    r                = '0;
    r.kind           = ROW_TYPED;
    r.value          = s;
    r.want.level     = level;
    r.want.alarm     = alarm;
    r.want.rep_level = rep_level;
    r.want.rep_alarm = rep_alarm;
    return r;
  endfunction

  // Gap before a sample beat: mostly none or short, now and then long.
  function automatic int pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (idle_off || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Mostly in-limit samples, with limit edges and full-range noise mixed in.
  function automatic logic [LIMIT_W-1:0] pick_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return LIMIT_W'($urandom_range(full_v, empty_v));
    if (pick < 88) return LIMIT_W'($urandom_range(0, 4095));
    if (pick < 91) return LIMIT_W'(empty_v - 1);
    if (pick < 94) return LIMIT_W'(full_v + 1);
    if (pick < 97) return LIMIT_W'(empty_v);
    return LIMIT_W'(full_v);
  endfunction

  // Offer one sample beat; the expectation is queued once the beat is taken.
  task automatic offer_sample(input logic [LIMIT_W-1:0] s, input bit typed,
                              input gauge_beat_t want);
    int gap;
    gauge_beat_t beat;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    voltage_sample_i <= s;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    beat = advance_gauge(s);
    if (typed) beat = want;
    expected_beats.push_back(beat);
    samples_sent++;
  endtask

  // Stop offering samples and wait until every expected beat has come out.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    case (idx)
      CFG_LOW_LIMIT:     empty_v  = data;
      CFG_HIGH_LIMIT:    full_v   = data;
      CFG_ALARM_PERCENT: alarm_at = data[PCT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: check each accepted beat and drive a random stall pattern.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_beats.size() == 0) begin
        flag_mismatch($sformatf("result beat with level %0d and no expectation waiting",
                                level_percent_o));
      end else begin
        head_beat = expected_beats.pop_front();
        if (level_percent_o !== head_beat.level)
          flag_mismatch($sformatf("beat %0d: level_percent %0d, expected %0d",
                                  beats_checked, level_percent_o, head_beat.level));
        if (low_alarm_o !== head_beat.alarm)
          flag_mismatch($sformatf("beat %0d: low_alarm %0b, expected %0b",
                                  beats_checked, low_alarm_o, head_beat.alarm));
        if (report_level_o !== head_beat.rep_level)
          flag_mismatch($sformatf("beat %0d: report_level %0b, expected %0b",
                                  beats_checked, report_level_o, head_beat.rep_level));
        if (report_alarm_o !== head_beat.rep_alarm)
          flag_mismatch($sformatf("beat %0d: report_alarm %0b, expected %0b",
                                  beats_checked, report_alarm_o, head_beat.rep_alarm));
      end
      beats_checked++;
    end

    if (stall_run > 0) begin
      stall_run = stall_run - 1;
    end else if (idle_off || $urandom_range(0, 99) < 55) begin
      out_stall_i <= 1'b0;
      stall_run = $urandom_range(1, 16);
    end else begin
      out_stall_i <= 1'b1;
      case ($urandom_range(0, 19))
        0:       stall_run = $urandom_range(20, 60);
        1, 2, 3: stall_run = $urandom_range(4, 12);
        default: stall_run = $urandom_range(0, 2);
      endcase
    end
  end

  // Watchdog: end the run when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    script_row_t script[$];
    script_row_t row;
    int unsigned lo;
    int unsigned hi;
    int unsigned al;
    int unsigned pick;
    int ph;
    int n;

    // Predicted state after reset.
    next_slot   = 0;
    kept_count  = 0;
    cur_level   = ZERO_PERCENT;
    level_dirty = 1'b0;
    cur_alarm   = 1'b0;
    alarm_dirty = 1'b0;
    empty_v     = LOW_LIMIT_RST;
    full_v      = HIGH_LIMIT_RST;
    alarm_at    = ALARM_PERCENT_RST;
    foreach (kept_samples[k]) kept_samples[k] = 0;

    // Directed script, starting from the reset limits 330..420 and alarm 15.
    // Sample extremes and the first fills of the store.
    script.push_back(typed_row(12'd0,    7'd0,   1'b0, 1'b0, 1'b0));
    script.push_back(typed_row(12'd4095, 7'd100, 1'b0, 1'b0, 1'b0));
    script.push_back(typed_row(12'd330,  7'd0,   1'b1, 1'b1, 1'b1));
    script.push_back(typed_row(12'd420,  7'd50,  1'b0, 1'b1, 1'b1));
    script.push_back(typed_row(12'd420,  7'd75,  1'b0, 1'b1, 1'b0));
    // Just outside the limits: the level changes, reports wait for an in-limit sample.
    script.push_back(typed_row(12'd329,  7'd0,   1'b0, 1'b0, 1'b0));
    script.push_back(typed_row(12'd421,  7'd100, 1'b0, 1'b0, 1'b0));
    script.push_back(sample_row(12'd375));
    // A write to the unused index must leave every register alone.
    script.push_back(cfg_row(CFG_UNUSED_IDX, 12'hFFF));
    script.push_back(sample_row(12'd331));
    // Alarm threshold at both extremes, the second with upper data bits set.
    script.push_back(cfg_row(CFG_ALARM_PERCENT, 12'd100));
    script.push_back(sample_row(12'd400));
    script.push_back(cfg_row(CFG_ALARM_PERCENT, 12'hF80));
    script.push_back(sample_row(12'd400));
    // Widest limits.
    script.push_back(cfg_row(CFG_LOW_LIMIT, 12'd0));
    script.push_back(cfg_row(CFG_HIGH_LIMIT, 12'd4095));
    script.push_back(sample_row(12'd0));
    script.push_back(sample_row(12'd4095));
    script.push_back(sample_row(12'd2048));
    // Stored samples below the new low limit saturate the level at zero.
    script.push_back(cfg_row(CFG_LOW_LIMIT, 12'd3000));
    script.push_back(cfg_row(CFG_HIGH_LIMIT, 12'd4000));
    script.push_back(sample_row(12'd3000));
    // Stored samples above the new high limit saturate the level at full.
    script.push_back(cfg_row(CFG_LOW_LIMIT, 12'd0));
    script.push_back(cfg_row(CFG_HIGH_LIMIT, 12'd1));
    script.push_back(sample_row(12'd1));
    // Zero span: a sample equal to both limits reads as full.
    script.push_back(cfg_row(CFG_LOW_LIMIT, 12'd500));
    script.push_back(cfg_row(CFG_HIGH_LIMIT, 12'd500));
    script.push_back(sample_row(12'd500));
    script.push_back(sample_row(12'd499));
    script.push_back(sample_row(12'd501));
    // Inverted limits: nothing is in range.
    script.push_back(cfg_row(CFG_LOW_LIMIT, 12'd4095));
    script.push_back(cfg_row(CFG_HIGH_LIMIT, 12'd0));
    script.push_back(sample_row(12'd2000));
    script.push_back(sample_row(12'd4095));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed script.
    settings_used = 1;
    foreach (script[r]) begin
      row = script[r];
      if (row.kind == ROW_CFG) begin
        settle_block();
        write_reg(row.idx, row.value);
        settings_used++;
      end else begin
        offer_sample(row.value, row.kind == ROW_TYPED, row.want);
      end
    end

    // Random phases, each under a fresh register setting.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle_block();
      idle_off = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: begin
          lo = LOW_LIMIT_RST;
          hi = HIGH_LIMIT_RST;
        end
        1: begin
          lo = 0;
          hi = 4095;
        end
        2: begin
          lo = $urandom_range(0, 4094);
          hi = $urandom_range(lo + 1, 4095);
        end
        3: begin
          lo = $urandom_range(0, 4075);
          hi = lo + $urandom_range(1, 20);
        end
        4: begin
          lo = $urandom_range(0, 4095);
          hi = lo;
        end
        5: begin
          hi = $urandom_range(0, 4094);
          lo = $urandom_range(hi + 1, 4095);
        end
        default: begin
          lo = $urandom_range(200, 400);
          hi = lo + $urandom_range(20, 300);
        end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 70)      al = $urandom_range(0, 100);
      else if (pick < 90) al = $urandom_range(0, 4095);
      else if (pick[0])   al = 100;
      else                al = 0;

      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_LOW_LIMIT, CFG_DATA_W'(lo));
        write_reg(CFG_HIGH_LIMIT, CFG_DATA_W'(hi));
      end else begin
        write_reg(CFG_HIGH_LIMIT, CFG_DATA_W'(hi));
        write_reg(CFG_LOW_LIMIT, CFG_DATA_W'(lo));
      end
      write_reg(CFG_ALARM_PERCENT, CFG_DATA_W'(al));
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom_range(0, 4095)));
      settings_used++;

      for (n = 0; n < PHASE_SAMPLES; n++) offer_sample(pick_sample(), 1'b0, '0);
    end

    // Drain, then give the block time to show any stray beat.
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d voltage samples under %0d register settings (%0d register writes).",
             samples_sent, settings_used, reg_writes);
    $display("Checked %0d result beats, %0d mismatches.", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* battery_level_gauge_core.f */
+incdir+rtl
rtl/blg_pkg.sv
rtl/blg_ctrl.sv
rtl/blg_dpath.sv
rtl/battery_level_gauge_core.sv
sim/testbench.sv
